/* rtl/core/assert_macros.svh */
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk and idle during reset
`define ETPC_ASSERT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define ETPC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/core/etpc_pkg.sv */
// shared types, constants and helpers of the two-point calibrator
package etpc_pkg;

    localparam int unsigned CHANNELS = 8;
    localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    localparam int unsigned SUM_W = 24;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned CNT_W = 8;
    localparam int unsigned HASH_W = 32;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_LIMIT = 16'd4095;
    localparam logic [HASH_W-1:0] HASH_SEED = 32'h1357_2468;
    localparam logic [LEVEL_W-1:0] MIN_DIFF_RESET = 16'd100;
    localparam logic [CNT_W-1:0] SAMPLES_RESET = 8'd50;

    typedef enum logic [1:0] {
        OP_RESET   = 2'd0,
        OP_CONFIRM = 2'd1,
        OP_SAMPLE  = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        STEP_IDLE       = 3'd0,
        STEP_ARMED      = 3'd1,
        STEP_WHITE      = 3'd2,
        STEP_WHITE_DONE = 3'd3,
        STEP_BLACK      = 3'd4,
        STEP_DONE       = 3'd5,
        STEP_FAILED     = 3'd6
    } step_t;

    typedef enum logic {
        REG_MIN_DIFF = 1'b0,
        REG_SAMPLES  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] frame_num;
        logic [15:0] channel_0;
        logic [15:0] channel_1;
        logic [15:0] channel_2;
        logic [15:0] channel_3;
        logic [15:0] channel_4;
        logic [15:0] channel_5;
        logic [15:0] channel_6;
        logic [15:0] channel_7;
    } item_t;

    typedef struct packed {
        logic [2:0]  step;
        logic [7:0]  sample_count;
        logic        success;
        logic [2:0]  channel_index;
        logic [15:0] white_level;
        logic [15:0] black_level;
        logic [31:0] record_checksum;
        logic        last;
    } result_t;

    typedef struct packed {
        logic            zero_samples;
        logic            start_capture;
        logic            accumulate;
        logic            div_start;
        logic [CH_W-1:0] div_idx;
        logic            level_write;
        logic            level_black;
        logic            hash_init;
        logic            hash_step;
        logic            hash_black;
        logic            load_out;
        logic            success;
        logic            last;
        logic [CH_W-1:0] idx;
        logic [2:0]      step;
    } etpc_cmd_t;

    typedef struct packed {
        logic frame_new;
        logic target_hit;
        logic div_done;
        logic pair_fail;
        logic out_free;
    } etpc_status_t;

    function automatic logic [LEVEL_W-1:0] item_channel(input item_t it, input int unsigned ch);
        logic [LEVEL_W-1:0] val;
        case (ch)
            0: val = it.channel_0;
            1: val = it.channel_1;
            2: val = it.channel_2;
            3: val = it.channel_3;
            4: val = it.channel_4;
            5: val = it.channel_5;
            6: val = it.channel_6;
            default: val = it.channel_7;
        endcase
        return val;
    endfunction

endpackage

/* rtl/core/etpc_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
module etpc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [etpc_pkg::SUM_W-1:0]  dividend,
    input  logic [7:0]                  divisor,
    output logic                        done,
    output logic [etpc_pkg::SUM_W-1:0]  quotient
);
    import etpc_pkg::*;

    localparam int unsigned STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [7:0]        rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [7:0]        div_reg, div_next;
    logic [8:0]        shifted;
    logic [8:0]        trial;
    logic              fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        trial   = shifted - {1'b0, div_reg};
        fits    = (shifted >= {1'b0, div_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so eight bits hold it
            rem_next = fits ? trial[7:0] : shifted[7:0];
            quo_next = {quo_reg[SUM_W-2:0], fits};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/etpc_dp.sv */
// datapath: config registers, sums, levels, checksum and result register
module etpc_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  etpc_pkg::item_t       item,
    input  logic                  cfg_valid,
    input  logic                  cfg_index,
    input  logic [etpc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  etpc_pkg::etpc_cmd_t   cmd,
    output etpc_pkg::etpc_status_t status,
    output logic                  result_valid,
    input  logic                  result_ready,
    output etpc_pkg::result_t     result
);
    import etpc_pkg::*;

    logic [LEVEL_W-1:0] min_diff_reg, min_diff_next;
    logic [CNT_W-1:0]   spc_reg, spc_next;
    logic [CNT_W-1:0]   samples_reg, samples_next;
    logic [31:0]        frame_reg, frame_next;
    logic [SUM_W-1:0]   sums_reg [CHANNELS];
    logic [SUM_W-1:0]   sums_next [CHANNELS];
    logic [LEVEL_W-1:0] white_reg [CHANNELS];
    logic [LEVEL_W-1:0] black_reg [CHANNELS];
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic               fail_reg, fail_next;
    logic               rvalid_reg, rvalid_next;
    result_t            result_reg, result_next;

    logic [CNT_W-1:0]   target;
    logic               div_done;
    logic [SUM_W-1:0]   quotient;
    logic [LEVEL_W-1:0] level_sat;
    logic [LEVEL_W-1:0] w_cur;
    logic [LEVEL_W-1:0] b_cur;
    logic [LEVEL_W-1:0] gap;
    logic               bad;

    // zero samples per capture behaves as one
    assign target = (spc_reg == '0) ? CNT_W'(1) : spc_reg;

    etpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sums_reg[cmd.div_idx]),
        .divisor  (target),
        .done     (div_done),
        .quotient (quotient)
    );

    assign level_sat = (quotient[SUM_W-1:LEVEL_W] != '0) ? '1 : quotient[LEVEL_W-1:0];

    assign w_cur = white_reg[cmd.idx];
    assign b_cur = black_reg[cmd.idx];
    assign gap   = (w_cur >= b_cur) ? (w_cur - b_cur) : (b_cur - w_cur);
    assign bad   = (w_cur > LEVEL_LIMIT) || (b_cur > LEVEL_LIMIT) || (gap < min_diff_reg);

    always_comb
    begin
        min_diff_next = min_diff_reg;
        spc_next      = spc_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_DIFF: min_diff_next = cfg_data;
                REG_SAMPLES:  spc_next = cfg_data[CNT_W-1:0];
            endcase
        end

        samples_next = samples_reg;
        frame_next   = frame_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            sums_next[i] = sums_reg[i];
        end

        if (cmd.zero_samples)
        begin
            samples_next = '0;
        end
        else if (cmd.start_capture)
        begin
            samples_next = '0;
            frame_next   = item.frame_num;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sums_next[i] = '0;
            end
        end
        else if (cmd.accumulate)
        begin
            frame_next = item.frame_num;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sums_next[i] = sums_reg[i] + SUM_W'(item_channel(item, i));
            end
            if (samples_reg != '1)
            begin
                samples_next = samples_reg + CNT_W'(1);
            end
        end

        hash_next = hash_reg;
        fail_next = fail_reg;
        if (cmd.hash_init)
        begin
            hash_next = HASH_SEED;
            fail_next = 1'b0;
        end
        else if (cmd.hash_step)
        begin
            // c * 33 + level, modulo 2^32
            hash_next = {hash_reg[HASH_W-6:0], 5'd0} + hash_reg
                        + HASH_W'(cmd.hash_black ? b_cur : w_cur);
            if (!cmd.hash_black && bad)
            begin
                fail_next = 1'b1;
            end
        end

        result_next = result_reg;
        rvalid_next = rvalid_reg;
        if (cmd.load_out)
        begin
            rvalid_next                 = 1'b1;
            result_next.step            = cmd.step;
            result_next.sample_count    = samples_reg;
            result_next.success         = cmd.success;
            result_next.channel_index   = cmd.success ? 3'(cmd.idx) : 3'd0;
            result_next.white_level     = cmd.success ? w_cur : '0;
            result_next.black_level     = cmd.success ? b_cur : '0;
            result_next.record_checksum = cmd.success ? hash_reg : '0;
            result_next.last            = cmd.last;
        end
        else if (result_ready)
        begin
            rvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_diff_reg <= MIN_DIFF_RESET;
            spc_reg      <= SAMPLES_RESET;
            samples_reg  <= '0;
            frame_reg    <= '0;
            hash_reg     <= '0;
            fail_reg     <= 1'b0;
            rvalid_reg   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sums_reg[i]  <= '0;
                white_reg[i] <= '0;
                black_reg[i] <= '0;
            end
        end
        else
        begin
            min_diff_reg <= min_diff_next;
            spc_reg      <= spc_next;
            samples_reg  <= samples_next;
            frame_reg    <= frame_next;
            hash_reg     <= hash_next;
            fail_reg     <= fail_next;
            rvalid_reg   <= rvalid_next;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sums_reg[i] <= sums_next[i];
            end
            if (cmd.level_write && !cmd.level_black)
            begin
                white_reg[cmd.idx] <= level_sat;
            end
            if (cmd.level_write && cmd.level_black)
            begin
                black_reg[cmd.idx] <= level_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign status.frame_new  = (item.frame_num != frame_reg);
    assign status.target_hit = (samples_reg >= target);
    assign status.div_done   = div_done;
    assign status.pair_fail  = fail_reg;
    assign status.out_free   = !rvalid_reg || result_ready;

    assign result_valid = rvalid_reg;
    assign result       = result_reg;

endmodule

/* rtl/core/etpc_ctrl.sv */
// controller: calibration step sequencer and datapath command issue
module etpc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [1:0]             opcode,
    input  etpc_pkg::etpc_status_t status,
    output etpc_pkg::etpc_cmd_t    cmd
);
    import etpc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_VALID,
        S_JUDGE,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    step_t           step_reg, step_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic            phase_reg, phase_next;
    logic            success_reg, success_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        ch_next      = ch_reg;
        phase_next   = phase_reg;
        success_next = success_reg;

        cmd         = '0;
        cmd.step    = step_reg;
        cmd.idx     = ch_reg;
        cmd.div_idx = ch_reg;
        cmd.success = success_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    success_next = 1'b0;
                    ch_next      = '0;
                    state_next   = S_OUT;
                    unique case (opcode_t'(opcode))
                        OP_RESET:
                        begin
                            step_next        = STEP_IDLE;
                            cmd.zero_samples = 1'b1;
                        end
                        OP_CONFIRM:
                        begin
                            if (step_reg == STEP_IDLE)
                            begin
                                step_next = STEP_ARMED;
                            end
                            else if (step_reg == STEP_ARMED)
                            begin
                                step_next         = STEP_WHITE;
                                cmd.start_capture = 1'b1;
                            end
                            else if (step_reg == STEP_WHITE_DONE)
                            begin
                                step_next         = STEP_BLACK;
                                cmd.start_capture = 1'b1;
                            end
                        end
                        OP_SAMPLE:
                        begin
                            if ((step_reg == STEP_WHITE || step_reg == STEP_BLACK)
                                && status.frame_new)
                            begin
                                cmd.accumulate = 1'b1;
                                state_next     = S_CHECK;
                            end
                        end
                        OP_NONE: ;
                    endcase
                end
            end
            S_CHECK:
            begin
                if (status.target_hit)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_idx   = '0;
                    ch_next       = '0;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.level_write = 1'b1;
                    cmd.level_black = (step_reg == STEP_BLACK);
                    if (ch_reg == LAST_CH)
                    begin
                        ch_next = '0;
                        if (step_reg == STEP_BLACK)
                        begin
                            cmd.hash_init = 1'b1;
                            phase_next    = 1'b0;
                            state_next    = S_VALID;
                        end
                        else
                        begin
                            step_next  = STEP_WHITE_DONE;
                            state_next = S_OUT;
                        end
                    end
                    else
                    begin
                        // next channel's division starts as this one retires
                        ch_next       = ch_reg + CH_W'(1);
                        cmd.div_start = 1'b1;
                        cmd.div_idx   = ch_reg + CH_W'(1);
                    end
                end
            end
            S_VALID:
            begin
                cmd.hash_step  = 1'b1;
                cmd.hash_black = phase_reg;
                phase_next     = !phase_reg;
                if (phase_reg)
                begin
                    if (ch_reg == LAST_CH)
                    begin
                        state_next = S_JUDGE;
                    end
                    else
                    begin
                        ch_next = ch_reg + CH_W'(1);
                    end
                end
            end
            S_JUDGE:
            begin
                step_next    = status.pair_fail ? STEP_FAILED : STEP_DONE;
                success_next = !status.pair_fail;
                ch_next      = '0;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.last     = !success_reg || (ch_reg == LAST_CH);
                    if (cmd.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next = ch_reg + CH_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= STEP_IDLE;
            ch_reg      <= '0;
            phase_reg   <= 1'b0;
            success_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            ch_reg      <= ch_next;
            phase_reg   <= phase_next;
            success_reg <= success_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);

endmodule

/* rtl/core/eight_channel_two_point_calibrator.sv */
// top level of the eight-channel two-point calibrator
//
// item channel (valid/ready): one event per beat: reset, confirm, none or frame
// sample with the frame count and eight channel readings.
// result channel (valid/ready): one beat per event, or eight beats (one per
// channel, last on the final one) when the event completes a valid pair.
// cfg channel (valid/ready, always ready): index 0 min_difference,
// index 1 samples_per_capture; the user must write them only while no event
// is in flight, which the block itself does not enforce.
// most events go straight to the output state; samples that add to a capture
// pass a check state first. a sample that ends a capture runs the shared
// radix-2 divider once per channel in turn; the black capture then hashes each
// channel's white and black level and passes a judge state before the results.
// the next event is accepted as soon as the last result beat is loaded,
// even if that beat still waits in the output register.
// a stalled receiver holds the result register; later beats wait for it.
// reset: step 0, counts and sums cleared, registers back to 100 and 50.
module eight_channel_two_point_calibrator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  etpc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output etpc_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [etpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import etpc_pkg::*;

    etpc_cmd_t    cmd;
    etpc_status_t status;

    assign cfg_ready = 1'b1;

    etpc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .opcode     (item.opcode),
        .status     (status),
        .cmd        (cmd)
    );

    etpc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* rtl/core/etpc_checker.sv */
// port-level checker for the calibrator, bound to the top level
`include "assert_macros.svh"

module etpc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input etpc_pkg::result_t result
);
    import etpc_pkg::*;

    // stalled beat holds
    `ETPC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result), "result beat changed while stalled")

    `ETPC_ASSERT(a_success_step, result_valid && result.success,
        result.step == STEP_DONE, "success beat without done step")

    // a plain beat carries no levels and closes its event
    `ETPC_ASSERT(a_plain_beat, result_valid && !result.success,
        result.last && result.channel_index == 3'd0 && result.white_level == 16'd0
        && result.black_level == 16'd0 && result.record_checksum == 32'd0,
        "plain beat carries channel data")

    // channel beats of a success burst follow back to back in order
    `ETPC_ASSERT_NEXT(a_burst_order,
        result_valid && result_ready && result.success && !result.last,
        result_valid && result.success
        && result.channel_index == 3'($past(result.channel_index) + 3'd1),
        "success burst out of order")

endmodule

bind eight_channel_two_point_calibrator etpc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
